@@ rtl/core/stis_pkg.sv @@
// stis_pkg: shared types, codes and sizes for the sorted table block
// no dependencies; used by every file in rtl/core
`timescale 1ns / 1ps

package stis_pkg;

    // default table size
    localparam int TABLE_DEPTH = 64;

    // result field widths
    localparam int POS_W  = 6;
    localparam int FILL_W = 7;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic              rejected;
        logic [FILL_W-1:0] fill_count;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic clear;
        logic insert;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       search_done;
    } t_status;

endpackage

@@ rtl/core/sorted_table_insert_and_search_top.sv @@
// sorted_table_insert_and_search_top: top level of the sorted table block
// depends on stis_pkg, stis_ctrl, stis_datapath
`timescale 1ns / 1ps

//  channel   ports                      handshake
//  request   start, i_request           taken at a clock edge with start high, busy low
//  result    o_strobe, o_result         held one cycle, taken at the edge that ends it
//
//  clear, insert and unused codes: the request passes compare and execute, then
//  the result strobe is raised in report
//  search: execute repeats one probe at a time until a hit or an empty range,
//  up to ceil(log2(fill+1)) probes
//  the probe loop over the per-cell compare vector sets the search time;
//  insert shifts every larger entry up the cell chain in parallel
//  synchronous active-low reset empties the table, no clearing pass
//  the receiver cannot stall; busy stays high until the result has gone out

module sorted_table_insert_and_search_top #(
    parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  stis_pkg::t_request i_request,
    output logic               busy,
    output logic               o_strobe,
    output stis_pkg::t_result  o_result
);

    // command and status between sequencer and datapath
    stis_pkg::t_cmd    w_cmd;
    stis_pkg::t_status w_status;

    // sequencer: idle, compare, execute (search probes loop here), report
    stis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // datapath: ordered cell chain with one comparator per cell
    stis_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_result  (o_result)
    );

endmodule

@@ rtl/core/stis_ctrl.sv @@
// stis_ctrl: sequencing state machine for the sorted table block
// depends on stis_pkg (command and status structs, op codes)
`timescale 1ns / 1ps

module stis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  stis_pkg::t_status i_status,
    output stis_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_EXECUTE,
        S_REPORT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_strobe, n_strobe;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COMPARE;
                end
            end
            S_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = S_EXECUTE;
            end
            S_EXECUTE: begin
                case (i_status.op)
                    stis_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_REPORT;
                    end
                    stis_pkg::OP_INSERT: begin
                        o_cmd.insert = 1'b1;
                        n_state      = S_REPORT;
                    end
                    stis_pkg::OP_SEARCH: begin
                        if (i_status.search_done) begin
                            n_state = S_REPORT;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_REPORT;
                    end
                endcase
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy   = (n_state != S_IDLE);
        n_strobe = (n_state == S_REPORT) && (r_state != S_REPORT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

@@ rtl/core/stis_datapath.sv @@
// stis_datapath: sorted cell chain, compare vectors and binary search registers
// depends on stis_pkg (request, result, command and status structs)
`timescale 1ns / 1ps

module stis_datapath #(
    parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stis_pkg::t_request i_request,
    input  stis_pkg::t_cmd     i_cmd,
    output stis_pkg::t_status  o_status,
    output stis_pkg::t_result  o_result
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [1:0]         r_op;
    logic signed [31:0] r_value;
    logic signed [31:0] r_entry [TABLE_DEPTH];
    logic [CW-1:0]      r_count;
    logic [TABLE_DEPTH-1:0] r_lt;
    logic [TABLE_DEPTH-1:0] r_gt;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;   // one past the upper bound
    logic               r_found;
    logic [IW-1:0]      r_pos;
    logic               r_rejected;

    logic [CW:0]        w_sum;
    logic [CW-1:0]      w_mid_full;
    logic [IW-1:0]      w_mid;
    logic               w_searching;
    logic               w_full;
    logic               w_do_insert;
    logic [TABLE_DEPTH-1:0] w_take;
    logic [IW+stis_pkg::POS_W-1:0]  w_pos_wide;
    logic [CW+stis_pkg::FILL_W-1:0] w_count_wide;

    // midpoint floor((lo + hi - 1) / 2) with hi held one past the bound
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi} - {{CW{1'b0}}, 1'b1};
    assign w_mid_full  = w_sum[CW:1];
    assign w_mid       = w_mid_full[IW-1:0];
    assign w_searching = (r_lo < r_hi);
    assign w_full      = (r_count == CW'(TABLE_DEPTH));
    assign w_do_insert = i_cmd.insert && !w_full;

    // cells that receive a new value on insert
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CW'(i) < r_count) begin
                w_take[i] = r_lt[i];
            end else begin
                w_take[i] = (CW'(i) == r_count);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_do_insert && w_take[g]) begin
                        r_entry[g] <= r_value;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (w_do_insert && w_take[g]) begin
                        r_entry[g] <= w_take[g-1] ? r_entry[g-1] : r_value;
                    end
                end
            end
        end
    endgenerate

    // one compare per cell
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_lt[i] <= (r_value < r_entry[i]);
                r_gt[i] <= (r_value > r_entry[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_request.op;
            r_value <= i_request.value;
        end
        if (i_cmd.compare) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.step && w_searching && !r_found) begin
            if (r_lt[w_mid]) begin
                r_hi <= w_mid_full;
            end else if (r_gt[w_mid]) begin
                r_lo <= w_mid_full + {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_found    <= 1'b0;
            r_pos      <= '0;
            r_rejected <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found    <= 1'b0;
                r_pos      <= '0;
                r_rejected <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end
            if (i_cmd.insert) begin
                if (w_full) begin
                    r_rejected <= 1'b1;
                end else begin
                    r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            if (i_cmd.step && w_searching && !r_found && !r_lt[w_mid] && !r_gt[w_mid]) begin
                r_found <= 1'b1;
                r_pos   <= w_mid;
            end
        end
    end

    assign o_status.op          = r_op;
    assign o_status.search_done = r_found || !w_searching;

    // fit index and count to the result field widths
    assign w_pos_wide   = {{stis_pkg::POS_W{1'b0}}, r_pos};
    assign w_count_wide = {{stis_pkg::FILL_W{1'b0}}, r_count};

    assign o_result.found      = r_found;
    assign o_result.position   = w_pos_wide[stis_pkg::POS_W-1:0];
    assign o_result.rejected   = r_rejected;
    assign o_result.fill_count = w_count_wide[stis_pkg::FILL_W-1:0];

endmodule

@@ rtl/core/stis_checker.sv @@
// stis_checker: port-level checks for the sorted table block
// depends on stis_pkg; bound to sorted_table_insert_and_search_top
`timescale 1ns / 1ps

module stis_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input stis_pkg::t_result o_result
);

    // a result only appears while a request is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe without a request in flight");

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after request accepted");

    // no result in the cycle right after acceptance
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result too early");

    // a result strobe is one cycle wide
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // a search hit and an insert drop never meet
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.found && o_result.rejected))
        else $error("found and rejected both set");

endmodule

bind sorted_table_insert_and_search_top stis_checker u_stis_checker (.*);
